// ===== src/dpne_pkg.sv =====
// Shared constants, types and the delta quantiser for the delta PCM nibble encoder.
`timescale 1ns / 1ps

package dpne_pkg;

    localparam int SampleWidth = 16;
    localparam int CodeWidth   = 4;
    localparam int ByteWidth   = 2 * CodeWidth;

    // Smallest magnitude that leaves the zero-step code.
    localparam logic signed [SampleWidth-1:0] DeadZoneMin = 16'sd256;
    localparam logic signed [SampleWidth-1:0] DeadZoneNeg = -16'sd255;
    // First threshold above the smallest step, doubled for every further code.
    localparam logic [SampleWidth:0] FirstThresh = 17'd512;
    localparam logic [SampleWidth:0] BaseStep    = 17'd256;

    localparam logic [CodeWidth-1:0] CodeZeroStep = 4'd8;
    localparam logic [CodeWidth-1:0] CodePosBase  = 4'd9;
    localparam logic [CodeWidth-1:0] CodeNegBase  = 4'd7;

    localparam logic signed [SampleWidth+1:0] PredMin = -18'sd32768;
    localparam logic signed [SampleWidth+1:0] PredMax = 18'sd32767;

    typedef logic signed [SampleWidth-1:0] sample_t;

    typedef struct packed {
        logic [CodeWidth-1:0]        code;
        logic signed [SampleWidth:0] step;
    } quant_t;

    // Quantise a wrapped delta into a code and its signed step.
    function automatic quant_t quantise(input sample_t d);
        quant_t              q;
        logic [2:0]          k;
        logic [SampleWidth:0] mag;
        logic [SampleWidth:0] stepmag;
        k       = 3'd0;
        mag     = 17'(-(18'(d)));
        stepmag = '0;
        if (d >= DeadZoneMin) begin
            // Positive side: up to six further doublings, top code saturates.
            for (int i = 0; i < 6; i++) begin
                if (17'(d) >= (FirstThresh << i)) begin
                    k = 3'(i + 1);
                end
            end
            stepmag = BaseStep << k;
            q.code  = CodePosBase + 4'(k);
            q.step  = signed'(stepmag);
        end else if (d >= DeadZoneNeg) begin
            q.code = CodeZeroStep;
            q.step = '0;
        end else begin
            // Negative side: up to seven doublings, the last one reaching full scale.
            for (int i = 0; i < 7; i++) begin
                if (mag >= (FirstThresh << i)) begin
                    k = 3'(i + 1);
                end
            end
            stepmag = BaseStep << k;
            q.code  = CodeNegBase - 4'(k);
            q.step  = -signed'(stepmag);
        end
        return q;
    endfunction

    // Add the step to the prediction at full width and saturate to 16 bits.
    function automatic sample_t next_pred(input sample_t pred,
                                          input logic signed [SampleWidth:0] step);
        logic signed [SampleWidth+1:0] sum;
        sample_t                       res;
        sum = 18'(pred) + 18'(step);
        if (sum <= PredMin) begin
            res = sample_t'(PredMin);
        end else if (sum >= PredMax) begin
            res = sample_t'(PredMax);
        end else begin
            res = sample_t'(sum);
        end
        return res;
    endfunction

endpackage

// ===== src/delta_pcm_nibble_encoder.sv =====
// A frame accepted into the input register moves on into the result register once that
// register is free or being emptied, and its code byte then shows on the result ports.
// Throughput: one frame per cycle while the result side is not stalled; both predictions
// are updated as a frame leaves the input register, so the next frame follows at once.
// Reset (aresetn low, synchronous): both predictions cleared, mono mode, both
// pipeline registers empty.
`timescale 1ns / 1ps

module delta_pcm_nibble_encoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [dpne_pkg::SampleWidth-1:0] s_first_sample,
    input  logic signed [dpne_pkg::SampleWidth-1:0] s_second_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [dpne_pkg::ByteWidth-1:0]   m_code_byte
);
    import dpne_pkg::*;

    logic     stereo_reg;
    logic     in_valid_reg;
    sample_t  first_in_reg;
    sample_t  second_in_reg;
    sample_t  first_pred_reg;
    sample_t  first_pred_next;
    sample_t  second_pred_reg;
    sample_t  second_pred_next;
    logic     out_valid_reg;
    logic [ByteWidth-1:0] code_byte_reg;
    logic [ByteWidth-1:0] code_byte_next;
    logic     advance;
    quant_t   q_first;
    quant_t   q_second;

    // The input beat moves on when the result register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stereo_reg <= 1'b0;
        end else if (cfg_we) begin
            stereo_reg <= cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            first_in_reg  <= s_first_sample;
            second_in_reg <= s_second_sample;
        end
    end

    // Quantise both channels against their predictions.
    always_comb begin
        q_first          = quantise(sample_t'(first_in_reg - first_pred_reg));
        q_second         = quantise(sample_t'(second_in_reg - second_pred_reg));
        first_pred_next  = next_pred(first_pred_reg, q_first.step);
        second_pred_next = stereo_reg ? next_pred(second_pred_reg, q_second.step)
                                      : second_pred_reg;
        code_byte_next   = stereo_reg ? {q_first.code, q_second.code}
                                      : {q_first.code, q_first.code};
    end

    // Prediction state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_pred_reg  <= '0;
            second_pred_reg <= '0;
        end else if (advance) begin
            first_pred_reg  <= first_pred_next;
            second_pred_reg <= second_pred_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            code_byte_reg <= code_byte_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_code_byte = code_byte_reg;

endmodule

// ===== src/dpne_checker.sv =====
// Port-level checker for the delta PCM nibble encoder, with its bind statement.
`timescale 1ns / 1ps

module dpne_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_we,
    input logic                           cfg_wdata,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [dpne_pkg::ByteWidth-1:0] m_code_byte
);
    import dpne_pkg::*;

    logic mode_reg;

    // Mirror of the mode as written on the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    // A stalled result beat keeps its byte.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_byte))
        else $error("result beat changed while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Reset leaves the input side open.
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // In mono both nibbles carry the same code.
    a_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !mode_reg |->
            m_code_byte[ByteWidth-1:CodeWidth] == m_code_byte[CodeWidth-1:0])
        else $error("mono beat with differing nibbles");

    // With the result side stalled and full, a new beat cannot pass the input register.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && !s_ready |=> m_valid)
        else $error("result lost while stalled");

endmodule

bind delta_pcm_nibble_encoder dpne_checker u_dpne_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_code_byte (m_code_byte)
);

// ===== tb/delta_pcm_nibble_encoder_tb.sv =====
// Self-checking testbench for the delta PCM nibble encoder, with its own code predictor.
`timescale 1ns / 1ps

module delta_pcm_nibble_encoder_tb;

    import dpne_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int DrainCycles = 6;
    localparam int IdlePercent = 7;

    // Quantiser constants used by the predictor.
    localparam int StepUnit  = 256;
    localparam int SampleMin = -32768;
    localparam int SampleMax = 32767;
    localparam logic MonoMode   = 1'b0;
    localparam logic StereoMode = 1'b1;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic                 cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    sample_t              s_first_sample;
    sample_t              s_second_sample;
    logic                 m_valid;
    logic                 m_ready;
    logic [ByteWidth-1:0] m_code_byte;

    // Predictor state, mirrored from what the block should hold.
    sample_t pred_first;
    sample_t pred_second;
    logic    stereo_on;

    logic [ByteWidth-1:0] expected_bytes[$];
    logic [ByteWidth-1:0] wanted_byte;
    int                   error_count;
    int                   cycle_count;
    int                   stall_cycles;
    bit                   quiet_run;

    delta_pcm_nibble_encoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_first_sample  (s_first_sample),
        .s_second_sample (s_second_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_byte     (m_code_byte)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit: a hung handshake ends the run as a failure.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("delta_pcm_nibble_encoder: mismatch");
            $finish;
        end
    end

    // Quantise one channel's sample against its prediction and move the prediction on.
    task automatic encode_channel(input sample_t smp, inout sample_t pred,
                                  output logic [3:0] code);
        sample_t wrapped;
        int      d;
        int      mag;
        int      stp;
        int      sum;
        int      k;
        wrapped = smp - pred;
        d       = wrapped;
        k       = 0;
        if (d >= StepUnit) begin
            while (k < 6 && d >= ((2 * StepUnit) << k)) k++;
            code = CodePosBase + 4'(k);
            stp  = StepUnit << k;
        end else if (d >= -(StepUnit - 1)) begin
            code = CodeZeroStep;
            stp  = 0;
        end else begin
            mag = -d;
            while (k < 7 && mag >= ((2 * StepUnit) << k)) k++;
            code = CodeNegBase - 4'(k);
            stp  = -(StepUnit << k);
        end
        // The sum is taken at full width, so it saturates rather than wraps.
        sum = int'(pred) + stp;
        if (sum <= SampleMin) begin
            sum = SampleMin;
        end else if (sum >= SampleMax) begin
            sum = SampleMax;
        end
        pred = sample_t'(sum);
    endtask

    // Work out the code byte for one accepted frame and queue it.
    task automatic predict_code_byte(input sample_t first, input sample_t second);
        logic [3:0] hi;
        logic [3:0] lo;
        encode_channel(first, pred_first, hi);
        if (stereo_on) begin
            encode_channel(second, pred_second, lo);
        end else begin
            lo = hi;
        end
        expected_bytes.push_back({hi, lo});
    endtask

    // Offer one frame, idling now and then beforehand, and wait until the block takes it.
    task automatic send_frame(input sample_t first, input sample_t second);
        while (!quiet_run && $urandom_range(99) < IdlePercent) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_first_sample  <= first;
        s_second_sample <= second;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_code_byte(first, second);
    endtask

    // Stop offering and wait until every queued code byte has been seen.
    task automatic wait_drained;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    // Write the mode register while the block is idle.
    task automatic write_mode(input logic mode);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        stereo_on  = mode;
    endtask

    // Pick a sample whose delta from the prediction spans every code band.
    function automatic sample_t random_sample(input sample_t pred);
        int unsigned pick;
        int          mag;
        sample_t     delta;
        pick = $urandom_range(15);
        if (pick < 4) begin
            return sample_t'($urandom);
        end else if (pick == 4) begin
            // Delta of exactly full negative scale.
            return pred + 16'sh8000;
        end
        mag   = $urandom_range(0, 1 << $urandom_range(0, 15));
        delta = sample_t'(mag);
        if ($urandom_range(1) == 1) begin
            delta = -delta;
        end
        return pred + delta;
    endfunction

    // Mono from reset: dead zone edges, full-scale swings and saturation at both rails.
    task automatic test_mono_directed;
        send_frame(16'sd0, 16'sh7FFF);
        send_frame(16'sd255, 16'sh8000);
        send_frame(-16'sd255, 16'sh5555);
        send_frame(16'sd256, 16'shAAAA);
        send_frame(-16'sd256, 16'sh0000);
        send_frame(16'sd32767, 16'shFFFF);
        send_frame(16'sd32767, 16'sh1234);
        send_frame(16'sd32767, 16'sh4321);
        send_frame(-16'sd32768, 16'sh7FFF);
        send_frame(-16'sd32768, 16'sh8000);
        send_frame(-16'sd32768, 16'sh0001);
        send_frame(16'sd16384, 16'shFFFE);
    endtask

    // Stereo: the second prediction is still zero after mono, so full-scale deltas follow.
    task automatic test_stereo_directed;
        write_mode(StereoMode);
        send_frame(16'sd32767, -16'sd32768);
        send_frame(-16'sd32768, 16'sd32767);
        send_frame(16'sd0, 16'sd0);
        send_frame(16'sd511, -16'sd511);
        send_frame(-16'sd1, 16'sd1);
        send_frame(16'sh7FFF, 16'sh7FFF);
        send_frame(16'sh8000, 16'sh8000);
    endtask

    // Mode changes keep both predictions as they stand.
    task automatic test_mode_change;
        write_mode(MonoMode);
        send_frame(16'sd1000, -16'sd20000);
        send_frame(-16'sd3000, 16'sd20000);
        write_mode(StereoMode);
        send_frame(16'sd1000, -16'sd20000);
        send_frame(-16'sd3000, 16'sd20000);
    endtask

    // Random frames aimed at the current predictions.
    task automatic test_random_frames(input int count);
        repeat (count) begin
            if (stereo_on) begin
                send_frame(random_sample(pred_first), random_sample(pred_second));
            end else begin
                send_frame(random_sample(pred_first), sample_t'($urandom));
            end
        end
    endtask

    // A stretch with no idling on either side.
    task automatic test_idle_free_stretch(input int count);
        quiet_run = 1'b1;
        test_random_frames(count);
        quiet_run = 1'b0;
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_output_stall(input int count);
        stall_cycles = 80;
        test_random_frames(count);
    endtask

    // The sender pauses until every result is out, then resumes.
    task automatic test_drain_pause(input int count);
        test_random_frames(count);
        wait_drained();
        test_random_frames(count);
    endtask

    // Receiver side: random back-pressure, plus any long hold-off that a test asks for.
    always @(posedge aclk) begin
        if (stall_cycles > 0) begin
            m_ready     <= 1'b0;
            stall_cycles = stall_cycles - 1;
        end else begin
            m_ready <= quiet_run || ($urandom_range(99) >= IdlePercent);
        end
    end

    // Compare each output beat against the oldest predicted code byte.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: code byte %h arrived with none expected", $time, m_code_byte);
                error_count++;
            end else begin
                wanted_byte = expected_bytes.pop_front();
                if (m_code_byte !== wanted_byte) begin
                    $display("%0t: code byte expected %h, got %h",
                             $time, wanted_byte, m_code_byte);
                    error_count++;
                end
            end
        end
    end

    // Reset, then the tests in turn, then the verdict.
    initial begin
        error_count     = 0;
        stall_cycles    = 0;
        quiet_run       = 1'b0;
        pred_first      = '0;
        pred_second     = '0;
        stereo_on       = MonoMode;
        aresetn         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= 1'b0;
        s_valid         <= 1'b0;
        s_first_sample  <= '0;
        s_second_sample <= '0;
        m_ready         <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_mono_directed();
        test_stereo_directed();
        test_mode_change();
        write_mode(MonoMode);
        test_random_frames(150);
        write_mode(StereoMode);
        test_idle_free_stretch(150);
        test_output_stall(40);
        write_mode(MonoMode);
        test_drain_pause(15);
        test_output_stall(20);
        write_mode(StereoMode);
        test_random_frames(260);

        wait_drained();
        if (error_count == 0) begin
            $display("delta_pcm_nibble_encoder: match");
        end else begin
            $display("delta_pcm_nibble_encoder: mismatch");
        end
        $finish;
    end

endmodule
